// File: rtl/core/oomf_pkg.sv
// shared types, constants and helpers for the overwrite-oldest message ring
package oomf_pkg;

   localparam int DEPTH        = 16;
   localparam int NUM_TYPES    = 8;
   localparam int PAYLOAD_BITS = 64;

   localparam int IDX_BITS       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TYPE_BITS      = 8;
   localparam int PORT_PAY_BITS  = 64;
   localparam int STATUS_BITS    = 2;

   typedef logic [IDX_BITS-1:0]      idx_type;
   typedef logic [TYPE_BITS-1:0]     msg_type_type;
   typedef logic [TYPE_BITS:0]       type_ext_type;
   typedef logic [PAYLOAD_BITS-1:0]  payload_type;
   typedef logic [PORT_PAY_BITS-1:0] port_payload_type;

   localparam type_ext_type TYPE_LIMIT = type_ext_type'(NUM_TYPES);
   localparam idx_type      IDX_LAST   = idx_type'(DEPTH - 1);

   // command codes of an input item
   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_SERVICE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EMPTY      = 2'd1,
      STATUS_BAD_TYPE   = 2'd2,
      STATUS_PUSH_EMPTY = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic read_head;
      logic push_commit;
      logic service_commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic is_service;
   } dp_sts_type;

   function automatic idx_type ring_next(input idx_type i);
      idx_type n;
      if (i == IDX_LAST) begin
         n = '0;
      end else begin
         n = i + idx_type'(1);
      end
      return n;
   endfunction

endpackage

// File: rtl/core/overwrite_oldest_message_fifo.sv
// top level of the overwrite-oldest message ring
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  request | req_valid req_stall req_cmd req_in_type            | in
//          | req_in_payload                                     |
//  result  | rsp_valid rsp_stall rsp_status rsp_dispatched      | out
//          | rsp_out_type rsp_out_payload                       |
//
// one item at a time, set by the controller sequence capture, head read / route, commit
// the result is registered in the output register at the commit step
// the slot memory read is registered, which takes the head read / route step
// a held result stalls the commit step; the item waits at commit and no new item is taken
// reset clears the pointers, controller and result valid; slot contents are not cleared
module overwrite_oldest_message_fifo (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic [oomf_pkg::TYPE_BITS-1:0]     req_in_type,
   input  logic [oomf_pkg::PORT_PAY_BITS-1:0] req_in_payload,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [oomf_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic                               rsp_dispatched,
   output logic [oomf_pkg::TYPE_BITS-1:0]     rsp_out_type,
   output logic [oomf_pkg::PORT_PAY_BITS-1:0] rsp_out_payload
);

   // command and status between controller and datapath
   oomf_pkg::dp_cmd_type dp_cmd;
   oomf_pkg::dp_sts_type dp_sts;

   // sequencer
   oomf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // ring storage, checks and result register
   oomf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .sts             (dp_sts),
      .req_cmd         (req_cmd),
      .req_in_type     (req_in_type),
      .req_in_payload  (req_in_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_dispatched  (rsp_dispatched),
      .rsp_out_type    (rsp_out_type),
      .rsp_out_payload (rsp_out_payload)
   );

endmodule

// File: rtl/core/oomf_ctrl.sv
// controller state machine: sequences capture, head read (service items only) and commit of one item
module oomf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  oomf_pkg::dp_sts_type sts,
   output oomf_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_PUSH = 4'b0100,
      ST_EVAL = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            // captured item decides the path
            if (sts.is_service) begin
               cmd.read_head = 1'b1;
               state_in      = ST_EVAL;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EVAL: begin
            if (sts.out_free) begin
               cmd.service_commit = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted but controller stayed open");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_commit || cmd.service_commit) |-> sts.out_free)
      else $error("commit while output register is held");

   a_head_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.read_head |=> (state_ff == ST_EVAL))
      else $error("head read not followed by evaluation");
`endif

endmodule

// File: rtl/core/oomf_dp.sv
// datapath: slot memory, ring pointers, service checks and result register
module oomf_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  oomf_pkg::dp_cmd_type             cmd,
   output oomf_pkg::dp_sts_type             sts,
   input  logic                             req_cmd,
   input  logic [oomf_pkg::TYPE_BITS-1:0]   req_in_type,
   input  logic [oomf_pkg::PORT_PAY_BITS-1:0] req_in_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [oomf_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_dispatched,
   output logic [oomf_pkg::TYPE_BITS-1:0]   rsp_out_type,
   output logic [oomf_pkg::PORT_PAY_BITS-1:0] rsp_out_payload
);

   // captured item
   logic                     cmd_ff;
   oomf_pkg::msg_type_type   type_ff;
   oomf_pkg::payload_type    payload_ff;

   // ring pointers
   oomf_pkg::idx_type        head_ff, head_in;
   oomf_pkg::idx_type        tail_ff, tail_in;

   // slot memory and registered head read
   oomf_pkg::msg_type_type   mem_type    [oomf_pkg::DEPTH];
   oomf_pkg::payload_type    mem_payload [oomf_pkg::DEPTH];
   oomf_pkg::msg_type_type   rd_type_ff;
   oomf_pkg::payload_type    rd_payload_ff;

   // result register
   logic                     out_valid_ff, out_valid_in;
   oomf_pkg::status_type     out_status_ff, out_status_in;
   logic                     out_disp_ff, out_disp_in;
   oomf_pkg::msg_type_type   out_type_ff, out_type_in;
   oomf_pkg::payload_type    out_payload_ff, out_payload_in;

   oomf_pkg::idx_type        tail_next;
   oomf_pkg::idx_type        head_after_push;
   oomf_pkg::idx_type        head_after_pop;
   logic                     ring_empty;
   logic                     bad_type;
   logic                     nil_payload;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff     <= req_cmd;
         type_ff    <= req_in_type;
         payload_ff <= req_in_payload[oomf_pkg::PAYLOAD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         mem_type[tail_ff]    <= type_ff;
         mem_payload[tail_ff] <= payload_ff;
      end
      if (cmd.read_head) begin
         rd_type_ff    <= mem_type[head_ff];
         rd_payload_ff <= mem_payload[head_ff];
      end
   end

   always_comb begin
      tail_next       = oomf_pkg::ring_next(tail_ff);
      // ring full: drop the oldest entry
      head_after_push = (tail_next == head_ff) ? oomf_pkg::ring_next(head_ff) : head_ff;
      head_after_pop  = oomf_pkg::ring_next(head_ff);
      ring_empty      = (head_ff == tail_ff);
      bad_type        = ({1'b0, rd_type_ff} >= oomf_pkg::TYPE_LIMIT);
      nil_payload     = (rd_payload_ff[7:0] == 8'd0);
   end

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_status_in  = out_status_ff;
      out_disp_in    = out_disp_ff;
      out_type_in    = out_type_ff;
      out_payload_in = out_payload_ff;
      if (cmd.push_commit) begin
         tail_in        = tail_next;
         head_in        = head_after_push;
         out_valid_in   = 1'b1;
         out_status_in  = (tail_next == head_after_push) ? oomf_pkg::STATUS_PUSH_EMPTY
                                                         : oomf_pkg::STATUS_OK;
         out_disp_in    = 1'b0;
         out_type_in    = '0;
         out_payload_in = '0;
      end else if (cmd.service_commit) begin
         out_valid_in   = 1'b1;
         out_disp_in    = 1'b0;
         out_type_in    = '0;
         out_payload_in = '0;
         if (ring_empty) begin
            out_status_in = oomf_pkg::STATUS_EMPTY;
         end else if (bad_type) begin
            out_status_in = oomf_pkg::STATUS_BAD_TYPE;
         end else if (nil_payload) begin
            out_status_in = oomf_pkg::STATUS_EMPTY;
         end else begin
            head_in        = head_after_pop;
            out_disp_in    = 1'b1;
            out_type_in    = rd_type_ff;
            out_payload_in = rd_payload_ff;
            out_status_in  = (head_after_pop == tail_ff) ? oomf_pkg::STATUS_EMPTY
                                                         : oomf_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_disp_ff    <= out_disp_in;
      out_type_ff    <= out_type_in;
      out_payload_ff <= out_payload_in;
   end

   assign sts.out_free   = !out_valid_ff || !rsp_stall;
   assign sts.is_service = (cmd_ff == oomf_pkg::CMD_SERVICE);

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_dispatched  = out_disp_ff;
   assign rsp_out_type    = out_type_ff;
   assign rsp_out_payload = oomf_pkg::port_payload_type'(out_payload_ff);

`ifndef SYNTHESIS
   a_push_leaves_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.push_commit |=> (head_ff != tail_ff))
      else $error("ring empty right after a push");

   a_pop_only_when_dispatched: assert property (@(posedge clock) disable iff (reset)
      cmd.service_commit |=> (rsp_dispatched == (head_ff != $past(head_ff))))
      else $error("head moved without a dispatch or the reverse");

   a_dispatch_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dispatched) |->
         (rsp_status == oomf_pkg::STATUS_OK || rsp_status == oomf_pkg::STATUS_EMPTY))
      else $error("dispatched item carries a fault status");
`endif

endmodule
